/* hw/rtl/mbns_pkg.sv */
// ----------------------------------------------------------------------------
// mbns_pkg
// Shared types and constants for the MP4 box parser and NAL splitter.
// ----------------------------------------------------------------------------
package mbns_pkg;

  localparam int unsigned BoxLenW  = 32;
  localparam int unsigned LeftW    = 24;
  localparam int unsigned BoxCntW  = 8;
  localparam int unsigned NalCntW  = 10;
  localparam int unsigned CfgDataW = 24;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned ResCntW  = 3;

  localparam logic [BoxLenW-1:0]  MdatType       = 32'h6d646174;
  localparam logic [BoxLenW-1:0]  HeaderLen      = 32'd8;
  localparam logic [BoxCntW-1:0]  MaxBoxesReset  = 8'd50;
  localparam logic [NalCntW-1:0]  MaxNalsReset   = 10'd100;
  localparam logic [LeftW-1:0]    MaxSizeReset   = 24'hffffff;

  localparam logic [ResCntW-1:0]  CntOne         = 3'd1;
  localparam logic [ResCntW-1:0]  CntWithNalByte = 3'd2;
  localparam logic [ResCntW-1:0]  CntWithStart   = 3'd5;
  localparam logic [ResCntW-1:0]  StartLastSlot  = 3'd4;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_MAX_BOXES    = 2'd0,
    CFG_MAX_NALS     = 2'd1,
    CFG_MAX_BOX_SIZE = 2'd2
  } cfg_idx_t;

  typedef enum logic [1:0] {
    KIND_PAYLOAD = 2'd0,
    KIND_NAL     = 2'd1,
    KIND_HEADER  = 2'd2,
    KIND_STOP    = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    STAT_OK       = 2'd0,
    STAT_BAD_SIZE = 2'd1,
    STAT_BOX_LIM  = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    PH_SIZE    = 2'd0,
    PH_TYPE    = 2'd1,
    PH_PAYLOAD = 2'd2,
    PH_STOPPED = 2'd3
  } phase_t;

  // All results caused by one input byte
  typedef struct packed {
    logic [ResCntW-1:0] cnt;
    kind_t              kind0;
    logic [7:0]         data;
    logic [BoxLenW-1:0] box_len;
    logic [BoxLenW-1:0] box_type;
    logic [BoxCntW-1:0] box_number;
    logic [NalCntW-1:0] nal_number;
    status_t            status;
  } bundle_t;

endpackage

/* hw/rtl/mbns_parser.sv */
// ----------------------------------------------------------------------------
// mbns_parser
// Box and NAL parse state; turns one input byte into a result bundle.
// ----------------------------------------------------------------------------
module mbns_parser (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [mbns_pkg::CfgIdxW-1:0]  cfg_index,
  input  logic [mbns_pkg::CfgDataW-1:0] cfg_data,
  input  logic                          step,
  input  logic [7:0]                    in_byte,
  output mbns_pkg::bundle_t             bundle
);

  logic [mbns_pkg::BoxCntW-1:0] max_boxes_r;
  logic [mbns_pkg::NalCntW-1:0] max_nals_r;
  logic [mbns_pkg::LeftW-1:0]   max_size_r;

  mbns_pkg::phase_t             phase_r, phase_nxt;
  logic [1:0]                   hdr_r, hdr_nxt;
  logic [mbns_pkg::BoxLenW-1:0] box_len_r, box_len_nxt;
  logic [mbns_pkg::BoxLenW-1:0] box_name_r, box_name_nxt;
  logic [mbns_pkg::LeftW-1:0]   left_r, left_nxt;
  logic                         media_r, media_nxt;
  logic [mbns_pkg::BoxLenW-1:0] nal_len_r, nal_len_nxt;
  logic [mbns_pkg::LeftW-1:0]   nal_left_r, nal_left_nxt;
  logic [1:0]                   pfx_r, pfx_nxt;
  logic                         nal_on_r, nal_on_nxt;
  logic [mbns_pkg::BoxCntW-1:0] boxes_r, boxes_nxt;
  logic [mbns_pkg::NalCntW-1:0] nals_r, nals_nxt;

  logic [mbns_pkg::BoxLenW-1:0] len_sh, name_sh, nal_len_sh;
  logic [mbns_pkg::LeftW-1:0]   left_dec;
  logic [mbns_pkg::LeftW-1:0]   nal_left_dec;
  logic                         nal_bad;

  assign len_sh       = (hdr_r == 2'd0) ? {24'd0, in_byte} : {box_len_r[23:0], in_byte};
  assign name_sh      = {box_name_r[23:0], in_byte};
  assign nal_len_sh   = {nal_len_r[23:0], in_byte};
  assign left_dec     = (left_r != '0) ? left_r - 24'd1 : left_r;
  assign nal_left_dec = nal_left_r - 24'd1;
  assign nal_bad      = (nal_len_sh == '0) || (nal_len_sh > {8'd0, left_dec}) ||
                        (nals_r >= max_nals_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_boxes_r <= mbns_pkg::MaxBoxesReset;
      max_nals_r  <= mbns_pkg::MaxNalsReset;
      max_size_r  <= mbns_pkg::MaxSizeReset;
    end else if (cfg_we) begin
      case (mbns_pkg::cfg_idx_t'(cfg_index))
        mbns_pkg::CFG_MAX_BOXES:    max_boxes_r <= cfg_data[mbns_pkg::BoxCntW-1:0];
        mbns_pkg::CFG_MAX_NALS:     max_nals_r  <= cfg_data[mbns_pkg::NalCntW-1:0];
        mbns_pkg::CFG_MAX_BOX_SIZE: max_size_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= mbns_pkg::PH_SIZE;
      hdr_r      <= '0;
      box_len_r  <= '0;
      box_name_r <= '0;
      left_r     <= '0;
      media_r    <= 1'b0;
      nal_len_r  <= '0;
      nal_left_r <= '0;
      pfx_r      <= '0;
      nal_on_r   <= 1'b0;
      boxes_r    <= '0;
      nals_r     <= '0;
    end else if (step) begin
      phase_r    <= phase_nxt;
      hdr_r      <= hdr_nxt;
      box_len_r  <= box_len_nxt;
      box_name_r <= box_name_nxt;
      left_r     <= left_nxt;
      media_r    <= media_nxt;
      nal_len_r  <= nal_len_nxt;
      nal_left_r <= nal_left_nxt;
      pfx_r      <= pfx_nxt;
      nal_on_r   <= nal_on_nxt;
      boxes_r    <= boxes_nxt;
      nals_r     <= nals_nxt;
    end
  end

  always_comb begin
    phase_nxt    = phase_r;
    hdr_nxt      = hdr_r;
    box_len_nxt  = box_len_r;
    box_name_nxt = box_name_r;
    left_nxt     = left_r;
    media_nxt    = media_r;
    nal_len_nxt  = nal_len_r;
    nal_left_nxt = nal_left_r;
    pfx_nxt      = pfx_r;
    nal_on_nxt   = nal_on_r;
    boxes_nxt    = boxes_r;
    nals_nxt     = nals_r;

    bundle.cnt        = '0;
    bundle.kind0      = mbns_pkg::KIND_PAYLOAD;
    bundle.data       = in_byte;
    bundle.box_len    = box_len_r;
    bundle.box_type   = box_name_r;
    bundle.box_number = boxes_r;
    bundle.nal_number = nals_r;
    bundle.status     = mbns_pkg::STAT_OK;

    case (phase_r)
      mbns_pkg::PH_SIZE: begin
        if (hdr_r == 2'd0 && boxes_r >= max_boxes_r) begin
          phase_nxt       = mbns_pkg::PH_STOPPED;
          bundle.cnt      = mbns_pkg::CntOne;
          bundle.kind0    = mbns_pkg::KIND_STOP;
          bundle.box_len  = '0;
          bundle.box_type = '0;
          bundle.status   = mbns_pkg::STAT_BOX_LIM;
        end else begin
          box_len_nxt = len_sh;
          hdr_nxt     = hdr_r + 2'd1;
          if (hdr_r == 2'd3) begin
            if (len_sh == '0 || len_sh > {8'd0, max_size_r}) begin
              phase_nxt       = mbns_pkg::PH_STOPPED;
              bundle.cnt      = mbns_pkg::CntOne;
              bundle.kind0    = mbns_pkg::KIND_STOP;
              bundle.box_len  = len_sh;
              bundle.box_type = '0;
              bundle.status   = mbns_pkg::STAT_BAD_SIZE;
            end else begin
              phase_nxt = mbns_pkg::PH_TYPE;
            end
          end
        end
      end
      mbns_pkg::PH_TYPE: begin
        box_name_nxt = name_sh;
        hdr_nxt      = hdr_r + 2'd1;
        if (hdr_r == 2'd3) begin
          boxes_nxt         = boxes_r + 8'd1;
          bundle.cnt        = mbns_pkg::CntOne;
          bundle.kind0      = mbns_pkg::KIND_HEADER;
          bundle.box_type   = name_sh;
          bundle.box_number = boxes_r + 8'd1;
          media_nxt         = (name_sh == mbns_pkg::MdatType);
          nal_on_nxt        = (name_sh == mbns_pkg::MdatType);
          nal_len_nxt       = '0;
          nal_left_nxt      = '0;
          pfx_nxt           = '0;
          if (box_len_r <= mbns_pkg::HeaderLen) begin
            left_nxt   = '0;
            nal_on_nxt = 1'b0;
            phase_nxt  = mbns_pkg::PH_SIZE;
          end else begin
            left_nxt  = box_len_r[23:0] - 24'd8;
            phase_nxt = mbns_pkg::PH_PAYLOAD;
          end
        end
      end
      mbns_pkg::PH_PAYLOAD: begin
        bundle.cnt = mbns_pkg::CntOne;
        left_nxt   = left_dec;
        if (media_r && nal_on_r) begin
          if (nal_left_r != '0) begin
            bundle.cnt   = mbns_pkg::CntWithNalByte;
            nal_left_nxt = nal_left_dec;
            if (nal_left_dec == '0) begin
              pfx_nxt = '0;
            end
          end else begin
            nal_len_nxt = nal_len_sh;
            pfx_nxt     = pfx_r + 2'd1;
            if (pfx_r == 2'd3) begin
              if (nal_bad) begin
                nal_on_nxt = 1'b0;
              end else begin
                nals_nxt          = nals_r + 10'd1;
                bundle.nal_number = nals_r + 10'd1;
                bundle.cnt        = mbns_pkg::CntWithStart;
                nal_left_nxt      = nal_len_sh[23:0];
              end
            end
          end
        end
        if (left_dec == '0) begin
          nal_on_nxt   = 1'b0;
          nal_left_nxt = '0;
          pfx_nxt      = '0;
          phase_nxt    = mbns_pkg::PH_SIZE;
        end
      end
      mbns_pkg::PH_STOPPED: begin
        bundle.cnt = '0;
      end
      default: begin
        phase_nxt = mbns_pkg::PH_STOPPED;
      end
    endcase
  end

endmodule

/* hw/rtl/mbns_serializer.sv */
// ----------------------------------------------------------------------------
// mbns_serializer
// Holds one result bundle and presents its results one transfer at a time.
// ----------------------------------------------------------------------------
module mbns_serializer (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 load,
  input  mbns_pkg::bundle_t                    bundle,
  output logic                                 busy,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic [1:0]                           out_kind,
  output logic [7:0]                           out_byte,
  output logic [mbns_pkg::BoxLenW-1:0]         out_box_len,
  output logic [mbns_pkg::BoxLenW-1:0]         out_box_type,
  output logic [mbns_pkg::BoxCntW-1:0]         out_box_number,
  output logic [mbns_pkg::NalCntW-1:0]         out_nal_number,
  output logic [1:0]                           out_status,
  output logic                                 out_last
);

  mbns_pkg::bundle_t              bund_r;
  logic                           valid_r;
  logic [mbns_pkg::ResCntW-1:0]   idx_r;
  logic                           take;
  logic                           last_now;

  assign last_now = (idx_r + 3'd1 == bund_r.cnt);
  assign take     = valid_r && !out_stall;
  assign busy     = valid_r && !(take && last_now);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      idx_r   <= '0;
    end else if (load) begin
      valid_r <= 1'b1;
      idx_r   <= '0;
    end else if (take) begin
      if (last_now) begin
        valid_r <= 1'b0;
      end else begin
        idx_r <= idx_r + 3'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      bund_r <= bundle;
    end
  end

  always_comb begin
    out_valid      = valid_r;
    out_last       = last_now;
    out_box_len    = bund_r.box_len;
    out_box_type   = bund_r.box_type;
    out_box_number = bund_r.box_number;
    out_status     = bund_r.status;
    if (idx_r == '0) begin
      out_kind       = bund_r.kind0;
      out_byte       = (bund_r.kind0 == mbns_pkg::KIND_PAYLOAD) ? bund_r.data : 8'd0;
      out_nal_number = '0;
    end else begin
      out_kind       = mbns_pkg::KIND_NAL;
      out_nal_number = bund_r.nal_number;
      if (bund_r.cnt == mbns_pkg::CntWithNalByte) begin
        out_byte = bund_r.data;
      end else begin
        out_byte = (idx_r == mbns_pkg::StartLastSlot) ? 8'd1 : 8'd0;
      end
    end
  end

endmodule

/* hw/rtl/mp4_box_and_nal_splitter_core.sv */
// ----------------------------------------------------------------------------
// mp4_box_and_nal_splitter_core
// MP4 box parser that copies box payloads and rewrites mdat NAL length
// prefixes as start codes.
// ----------------------------------------------------------------------------
// Usage:
//   Feed the file one byte per in_valid/in_stall transfer. Each byte yields
//   zero to five results on the out_ channel; out_last marks the final one
//   for that byte. Results come one per transfer.
//   A byte's results are registered at the edge that accepts it, and the
//   first is shown in the cycle after.
//   Throughput: one byte per cycle while each byte yields at most one
//   result and out_stall stays low. As the single result register holds
//   one byte's results, a byte carrying a NAL byte holds the input until
//   both are taken and a completed length prefix (start code) until all
//   five are. Bytes with no result pass at one per cycle if none is pending.
//   Stalls: out_stall holds the current result; in_stall rises while the
//   result register cannot take a new byte's results.
//   Reset: rst_n low clears parse state and restores max_boxes 50,
//   max_nals 100 and a box size limit of 0xffffff. After a stop result all
//   further bytes are dropped until reset. Write cfg_ only while idle.
// ----------------------------------------------------------------------------
module mp4_box_and_nal_splitter_core (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [mbns_pkg::CfgIdxW-1:0]  cfg_index,
  input  logic [mbns_pkg::CfgDataW-1:0] cfg_data,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [7:0]                    in_byte,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [1:0]                    out_kind,
  output logic [7:0]                    out_byte,
  output logic [mbns_pkg::BoxLenW-1:0]  out_box_len,
  output logic [mbns_pkg::BoxLenW-1:0]  out_box_type,
  output logic [mbns_pkg::BoxCntW-1:0]  out_box_number,
  output logic [mbns_pkg::NalCntW-1:0]  out_nal_number,
  output logic [1:0]                    out_status,
  output logic                          out_last
);

  mbns_pkg::bundle_t bundle;
  logic              in_fire;
  logic              busy;
  logic              load;

  assign in_stall = busy;
  assign in_fire  = in_valid && !busy;
  assign load     = in_fire && (bundle.cnt != '0);

  mbns_parser u_parser (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .step      (in_fire),
    .in_byte   (in_byte),
    .bundle    (bundle)
  );

  mbns_serializer u_ser (
    .clk            (clk),
    .rst_n          (rst_n),
    .load           (load),
    .bundle         (bundle),
    .busy           (busy),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_kind       (out_kind),
    .out_byte       (out_byte),
    .out_box_len    (out_box_len),
    .out_box_type   (out_box_type),
    .out_box_number (out_box_number),
    .out_nal_number (out_nal_number),
    .out_status     (out_status),
    .out_last       (out_last)
  );

`ifndef NO_ASSERTIONS
  a_stall_needs_result: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> !in_stall)
    else $error("input stalled with no result pending");

  a_stop_is_final: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_stall && out_kind == mbns_pkg::KIND_STOP) |=> !out_valid)
    else $error("result after stop");

  a_status_only_on_stop: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status != mbns_pkg::STAT_OK) |-> out_kind == mbns_pkg::KIND_STOP)
    else $error("nonzero status on non-stop result");

  a_nal_number_on_nal: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_nal_number != '0) |-> out_kind == mbns_pkg::KIND_NAL)
    else $error("NAL number on non-NAL result");
`endif

endmodule

/* bench/tb_mp4_box_and_nal_splitter_core.sv */
// ----------------------------------------------------------------------------
// tb_mp4_box_and_nal_splitter_core
// Self-checking bench for the MP4 box parser and NAL splitter. A short
// directed file is followed by random boxes. The random boxes are mostly mdat
// boxes carrying well-formed NAL length prefixes, with broken prefixes, short
// boxes and plain boxes mixed in, under several register settings. The run
// closes with one terminal stop, either the box limit or a bad box size.
// Every result transfer is checked field by field against an in-bench model
// of the parser. Both channels idle at random until 360 bytes have been fed.
// ----------------------------------------------------------------------------
module tb_mp4_box_and_nal_splitter_core;
  import mbns_pkg::*;

  typedef struct {
    kind_t        kind;
    logic [7:0]   data;
    logic [31:0]  box_len;
    logic [31:0]  box_type;
    logic [7:0]   box_number;
    logic [9:0]   nal_number;
    status_t      status;
    logic         last;
  } split_result_t;

  typedef struct {
    logic [7:0] b;
    bit         chk;
    kind_t      k;
    logic [7:0] d;
  } dir_row_t;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                cfg_we = 1'b0;
  logic [CfgIdxW-1:0]  cfg_index = '0;
  logic [CfgDataW-1:0] cfg_data = '0;
  logic                in_valid = 1'b0;
  logic                in_stall;
  logic [7:0]          in_byte = 8'h00;
  logic                out_valid;
  logic                out_stall = 1'b0;
  logic [1:0]          out_kind;
  logic [7:0]          out_byte;
  logic [BoxLenW-1:0]  out_box_len;
  logic [BoxLenW-1:0]  out_box_type;
  logic [BoxCntW-1:0]  out_box_number;
  logic [NalCntW-1:0]  out_nal_number;
  logic [1:0]          out_status;
  logic                out_last;

  mp4_box_and_nal_splitter_core u_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_byte        (in_byte),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_kind       (out_kind),
    .out_byte       (out_byte),
    .out_box_len    (out_box_len),
    .out_box_type   (out_box_type),
    .out_box_number (out_box_number),
    .out_nal_number (out_nal_number),
    .out_status     (out_status),
    .out_last       (out_last)
  );

  // parser model state
  phase_t       ph = PH_SIZE;
  logic [1:0]   hdr_cnt = '0;
  logic [31:0]  box_len = '0;
  logic [31:0]  box_name = '0;
  logic [23:0]  box_left = '0;
  logic         in_mdat = 1'b0;
  logic [31:0]  nal_len = '0;
  logic [23:0]  nal_left = '0;
  logic [1:0]   prefix_cnt = '0;
  logic         nal_on = 1'b0;
  logic [7:0]   n_boxes = '0;
  logic [9:0]   n_nals = '0;
  logic [7:0]   lim_boxes = MaxBoxesReset;
  logic [9:0]   lim_nals = MaxNalsReset;
  logic [23:0]  lim_size = MaxSizeReset;

  split_result_t expected_q[$];
  int            idle_in = 36;
  int            idle_out = 64;
  int            fed_cnt = 0;
  int            checked_cnt = 0;
  int            err_cnt = 0;

  split_result_t want;
  logic [31:0]   want_f[8];
  logic [31:0]   got_f[8];
  string         field_names[8] = '{"kind", "out_byte", "box_len", "box_type",
                                    "box_number", "nal_number", "status", "last"};

  dir_row_t directed_rows[23] = '{
    '{8'h00, 1'b0, KIND_PAYLOAD, 8'h00}, '{8'h00, 1'b0, KIND_PAYLOAD, 8'h00},
    '{8'h00, 1'b0, KIND_PAYLOAD, 8'h00}, '{8'h01, 1'b0, KIND_PAYLOAD, 8'h00},
    '{8'hff, 1'b0, KIND_PAYLOAD, 8'h00}, '{8'hff, 1'b0, KIND_PAYLOAD, 8'h00},
    '{8'hff, 1'b0, KIND_PAYLOAD, 8'h00}, '{8'hff, 1'b1, KIND_HEADER,  8'h00},
    '{8'h00, 1'b0, KIND_PAYLOAD, 8'h00}, '{8'h00, 1'b0, KIND_PAYLOAD, 8'h00},
    '{8'h00, 1'b0, KIND_PAYLOAD, 8'h00}, '{8'h0f, 1'b0, KIND_PAYLOAD, 8'h00},
    '{8'h6d, 1'b0, KIND_PAYLOAD, 8'h00}, '{8'h64, 1'b0, KIND_PAYLOAD, 8'h00},
    '{8'h61, 1'b0, KIND_PAYLOAD, 8'h00}, '{8'h74, 1'b1, KIND_HEADER,  8'h00},
    '{8'h00, 1'b1, KIND_PAYLOAD, 8'h00}, '{8'h00, 1'b1, KIND_PAYLOAD, 8'h00},
    '{8'h00, 1'b1, KIND_PAYLOAD, 8'h00}, '{8'h03, 1'b1, KIND_NAL,     8'h01},
    '{8'hff, 1'b1, KIND_NAL,     8'hff}, '{8'h80, 1'b1, KIND_NAL,     8'h80},
    '{8'h7f, 1'b1, KIND_NAL,     8'h7f}
  };

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #3000000;
    $display("** mp4_box_and_nal_splitter_core: FAILED **");
    $finish;
  end

  function automatic void add_result(kind_t k, logic [7:0] d, logic [9:0] nal,
                                     status_t st, logic [31:0] sz, logic [31:0] ty);
    split_result_t r;
    r.kind       = k;
    r.data       = d;
    r.box_len    = sz;
    r.box_type   = ty;
    r.box_number = n_boxes;
    r.nal_number = nal;
    r.status     = st;
    r.last       = 1'b0;
    expected_q.push_back(r);
  endfunction

  function automatic void parse_byte(logic [7:0] b);
    int            first;
    split_result_t tail;
    first = expected_q.size();
    case (ph)
      PH_SIZE: begin
        if (hdr_cnt == 2'd0 && n_boxes >= lim_boxes) begin
          ph = PH_STOPPED;
          add_result(KIND_STOP, 8'h00, '0, STAT_BOX_LIM, 32'd0, 32'd0);
        end else begin
          box_len = ((hdr_cnt == 2'd0) ? 32'd0 : (box_len << 8)) | {24'd0, b};
          hdr_cnt = hdr_cnt + 2'd1;
          if (hdr_cnt == 2'd0) begin
            if (box_len == 32'd0 || box_len > {8'd0, lim_size}) begin
              ph = PH_STOPPED;
              add_result(KIND_STOP, 8'h00, '0, STAT_BAD_SIZE, box_len, 32'd0);
            end else begin
              ph = PH_TYPE;
            end
          end
        end
      end
      PH_TYPE: begin
        box_name = {box_name[23:0], b};
        hdr_cnt  = hdr_cnt + 2'd1;
        if (hdr_cnt == 2'd0) begin
          n_boxes = n_boxes + 8'd1;
          add_result(KIND_HEADER, 8'h00, '0, STAT_OK, box_len, box_name);
          in_mdat    = (box_name == MdatType);
          nal_on     = in_mdat;
          nal_len    = '0;
          nal_left   = '0;
          prefix_cnt = '0;
          if (box_len <= HeaderLen) begin
            box_left = '0;
            nal_on   = 1'b0;
            ph       = PH_SIZE;
          end else begin
            box_left = 24'(box_len - HeaderLen);
            ph       = PH_PAYLOAD;
          end
        end
      end
      PH_PAYLOAD: begin
        add_result(KIND_PAYLOAD, b, '0, STAT_OK, box_len, box_name);
        if (box_left != '0) box_left = box_left - 24'd1;
        if (in_mdat && nal_on) begin
          if (nal_left != '0) begin
            add_result(KIND_NAL, b, n_nals, STAT_OK, box_len, box_name);
            nal_left = nal_left - 24'd1;
            if (nal_left == '0) prefix_cnt = '0;
          end else begin
            nal_len    = {nal_len[23:0], b};
            prefix_cnt = prefix_cnt + 2'd1;
            if (prefix_cnt == 2'd0) begin
              if (nal_len == 32'd0 || nal_len > {8'd0, box_left} || n_nals >= lim_nals) begin
                nal_on = 1'b0;
              end else begin
                n_nals = n_nals + 10'd1;
                for (int k = 0; k < 4; k++) begin
                  add_result(KIND_NAL, (k == 3) ? 8'h01 : 8'h00, n_nals, STAT_OK,
                             box_len, box_name);
                end
                nal_left = nal_len[23:0];
              end
            end
          end
        end
        if (box_left == '0) begin
          nal_on     = 1'b0;
          nal_left   = '0;
          prefix_cnt = '0;
          ph         = PH_SIZE;
        end
      end
      default: begin
      end
    endcase
    if (expected_q.size() > first) begin
      tail      = expected_q.pop_back();
      tail.last = 1'b1;
      expected_q.push_back(tail);
    end
  endfunction

  task automatic send_byte(input logic [7:0] b);
    if (fed_cnt < 180) begin
      idle_in  = 36;
      idle_out = 64;
    end else if (fed_cnt < 360) begin
      idle_in  = 64;
      idle_out = 36;
    end else begin
      idle_in  = 0;
      idle_out = 0;
    end
    while ($urandom_range(99) < idle_in) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_byte  <= b;
    do @(posedge clk); while (in_stall);
    parse_byte(b);
    fed_cnt++;
  endtask

  task automatic put_word(input logic [31:0] w);
    for (int i = 3; i >= 0; i--) send_byte(w[8*i +: 8]);
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_idx_t idx, input logic [23:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_MAX_BOXES:    lim_boxes = val[7:0];
      CFG_MAX_NALS:     lim_nals  = val[9:0];
      CFG_MAX_BOX_SIZE: lim_size  = val;
      default: begin
      end
    endcase
    @(posedge clk);
  endtask

  task automatic send_random_box();
    logic [31:0] sz;
    logic [31:0] ty;
    logic [31:0] nl;
    int unsigned room;
    int unsigned cap;
    int unsigned pick;
    bit          broken;
    pick = $urandom_range(99);
    if (pick < 55) ty = MdatType;
    else if (pick < 70) ty = 32'h66726565;
    else if (pick < 80) ty = MdatType ^ (32'd1 << $urandom_range(31));
    else ty = $urandom;
    cap = (ty == MdatType) ? 90 : 40;
    if (cap > lim_size) cap = lim_size;
    if (cap <= 9 || $urandom_range(9) == 0) sz = $urandom_range(1, 9);
    else sz = $urandom_range(9, cap);
    put_word(sz);
    put_word(ty);
    room   = (sz > 8) ? sz - 8 : 0;
    broken = (ty != MdatType);
    while (room > 0) begin
      if (broken || room < 5) begin
        send_byte(8'($urandom));
        room--;
      end else if ($urandom_range(7) != 0) begin
        if ($urandom_range(3) == 0) nl = room - 4;
        else nl = $urandom_range(1, (room - 4 < 24) ? room - 4 : 24);
        put_word(nl);
        repeat (nl) send_byte(8'($urandom));
        room -= 4 + nl;
      end else begin
        pick = $urandom_range(2);
        if (pick == 0) nl = 32'd0;
        else if (pick == 1) nl = room - 3;
        else nl = $urandom | 32'h8000_0000;
        put_word(nl);
        room  -= 4;
        broken = 1'b1;
      end
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      checked_cnt++;
      if (expected_q.size() == 0) begin
        err_cnt++;
        $display("%0t: result with none expected: kind %0d byte %h", $time, out_kind,
                 out_byte);
      end else begin
        want   = expected_q.pop_front();
        want_f = '{32'(want.kind), 32'(want.data), want.box_len, want.box_type,
                   32'(want.box_number), 32'(want.nal_number), 32'(want.status),
                   32'(want.last)};
        got_f  = '{32'(out_kind), 32'(out_byte), out_box_len, out_box_type,
                   32'(out_box_number), 32'(out_nal_number), 32'(out_status),
                   32'(out_last)};
        for (int i = 0; i < 8; i++) begin
          if (got_f[i] !== want_f[i]) begin
            err_cnt++;
            $display("%0t: %s expected %h got %h", $time, field_names[i], want_f[i],
                     got_f[i]);
          end
        end
      end
    end
    out_stall <= ($urandom_range(99) < idle_out);
  end

  initial begin
    int unsigned   pick;
    logic [31:0]   sz;
    split_result_t tail;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_rows[i]) begin
      send_byte(directed_rows[i].b);
      if (directed_rows[i].chk) begin
        tail      = expected_q.pop_back();
        tail.kind = directed_rows[i].k;
        tail.data = directed_rows[i].d;
        expected_q.push_back(tail);
      end
    end

    wait_idle();
    write_reg(CFG_MAX_BOXES, 24'd255);
    write_reg(CFG_MAX_NALS, 24'd1023);
    write_reg(CFG_MAX_BOX_SIZE, 24'hffffff);
    while (fed_cnt < 170) send_random_box();

    // limit the NAL count to two above its current value
    wait_idle();
    write_reg(CFG_MAX_NALS, 24'(n_nals) + 24'd2);
    write_reg(CFG_MAX_BOX_SIZE, 24'($urandom_range(80, 4096)));
    while (fed_cnt < 280) send_random_box();

    wait_idle();
    write_reg(CFG_MAX_BOX_SIZE, 24'd9);
    write_reg(CFG_MAX_NALS, 24'd1);
    while (fed_cnt < 340) send_random_box();

    wait_idle();
    write_reg(CFG_MAX_NALS, 24'd1023);
    write_reg(CFG_MAX_BOX_SIZE, 24'hffffff);
    while (fed_cnt < 460) send_random_box();

    // end parsing for good, then feed bytes that must be dropped
    wait_idle();
    pick = $urandom_range(2);
    if (pick == 0) begin
      write_reg(CFG_MAX_BOXES, 24'd1);
      sz = 32'd16;
    end else if (pick == 1) begin
      write_reg(CFG_MAX_BOX_SIZE, 24'd9);
      sz = $urandom_range(1) ? 32'd10 : ($urandom | 32'h0100_0000);
    end else begin
      sz = 32'd0;
    end
    put_word(sz);
    put_word(MdatType);
    repeat (6) send_byte(8'($urandom));
    wait_idle();
    repeat (12) @(posedge clk);

    $display("Fed %0d bytes and checked %0d results over %0d boxes and %0d NAL units,",
             fed_cnt, checked_cnt, n_boxes, n_nals);
    $display("ending with stop case %0d (0 box limit, 1 oversized box, 2 zero size).", pick);
    if (err_cnt == 0 && expected_q.size() == 0) begin
      $display("** mp4_box_and_nal_splitter_core: PASSED **");
    end else begin
      $display("** mp4_box_and_nal_splitter_core: FAILED **");
    end
    $finish;
  end

endmodule

/* files.f */
hw/rtl/mbns_pkg.sv
hw/rtl/mbns_parser.sv
hw/rtl/mbns_serializer.sv
hw/rtl/mp4_box_and_nal_splitter_core.sv
bench/tb_mp4_box_and_nal_splitter_core.sv
